/* rtl/core/rua_pkg.sv */
`default_nettype none
package rua_pkg;

    // Sizing
    localparam int NUM_VIEWS     = 8;
    localparam int APPS_PER_VIEW = 16;
    localparam int SLOTS         = NUM_VIEWS * APPS_PER_VIEW;
    localparam int VIEW_W        = (NUM_VIEWS > 1) ? $clog2(NUM_VIEWS) : 1;
    localparam int SLOT_W        = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W         = $clog2(APPS_PER_VIEW + 1);
    localparam int RK_W          = (CNT_W > 4) ? CNT_W : 4;

    // Request kinds
    localparam logic [2:0] K_ACQUIRE = 3'd0;
    localparam logic [2:0] K_RELEASE = 3'd1;
    localparam logic [2:0] K_AVAIL   = 3'd2;
    localparam logic [2:0] K_USAGE   = 3'd3;
    localparam logic [2:0] K_USED    = 3'd4;
    localparam logic [2:0] K_ENTRY   = 3'd5;
    localparam logic [2:0] K_DELETE  = 3'd6;

    // Result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NO_VIEW   = 3'd1;
    localparam logic [2:0] ST_NO_ENTRY  = 3'd2;
    localparam logic [2:0] ST_OVER      = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;
    localparam logic [2:0] ST_PROTECTED = 3'd5;

    // Register indexes
    localparam logic [7:0] REG_CAPACITY = 8'd0;
    localparam logic [7:0] REG_SYSVIEW  = 8'd1;

    typedef struct packed {
        logic load;
        logic prep;
        logic scan_go;
        logic rank_mode;
        logic cand_load;
        logic outer_inc;
        logic found;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic need_scan;
        logic need_rank;
        logic scan_done;
        logic cand_valid;
        logic rank_hit;
        logic outer_last;
        logic out_busy;
    } stat_t;

endpackage
`default_nettype wire

/* rtl/core/rua_ctrl.sv */
`default_nettype none
module rua_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  rua_pkg::stat_t     st,
    output rua_pkg::cmd_t      cmd
);
    import rua_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_PREP   = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_FETCH  = 3'd3;
    localparam logic [2:0] S_FWAIT  = 3'd4;
    localparam logic [2:0] S_RANK   = 3'd5;
    localparam logic [2:0] S_NEXT   = 3'd6;
    localparam logic [2:0] S_FINISH = 3'd7;

    logic [2:0] state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE);

    // Sequencer
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_PREP;
                end
            end
            S_PREP: begin
                cmd.prep = 1'b1;
                if (st.need_scan) begin
                    cmd.scan_go = 1'b1;
                    state_next  = S_SCAN;
                end else if (st.need_rank) begin
                    state_next = S_FETCH;
                end else begin
                    state_next = S_FINISH;
                end
            end
            S_SCAN: begin
                if (st.scan_done) state_next = S_FINISH;
            end
            S_FETCH: begin
                state_next = S_FWAIT;
            end
            S_FWAIT: begin
                cmd.cand_load = 1'b1;
                if (st.cand_valid) begin
                    cmd.scan_go   = 1'b1;
                    cmd.rank_mode = 1'b1;
                    state_next    = S_RANK;
                end else begin
                    state_next = S_NEXT;
                end
            end
            S_RANK: begin
                if (st.scan_done) state_next = S_NEXT;
            end
            S_NEXT: begin
                if (st.rank_hit) begin
                    cmd.found  = 1'b1;
                    state_next = S_FINISH;
                end else if (st.outer_last) begin
                    state_next = S_FINISH;
                end else begin
                    cmd.outer_inc = 1'b1;
                    state_next    = S_FETCH;
                end
            end
            S_FINISH: begin
                if (!st.out_busy) begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= S_IDLE;
        else          state_reg <= state_next;
    end

endmodule
`default_nettype wire

/* rtl/core/rua_dp.sv */
`default_nettype none
module rua_dp (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic [2:0]    in_kind,
    input  wire logic [71:0]   in_data,
    input  wire logic          cfg_we,
    input  wire logic [7:0]    cfg_index,
    input  wire logic [31:0]   cfg_value,
    input  rua_pkg::cmd_t      cmd,
    output rua_pkg::stat_t     st,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [71:0]        out_data
);
    import rua_pkg::*;

    localparam logic [SLOT_W-1:0] APPS_S = SLOT_W'(APPS_PER_VIEW);
    localparam logic [CNT_W-1:0]  LAST_J = CNT_W'(APPS_PER_VIEW - 1);

    // Request word and configuration
    logic [2:0]  kind_reg, slot_reg;
    logic        in_range_reg;
    logic [31:0] app_reg, amt_reg;
    logic [3:0]  idx_reg;
    logic        cnta_reg;
    logic [31:0] cap_reg;
    logic [2:0]  sysv_reg;

    // Accounting state
    logic [NUM_VIEWS-1:0] vpres_reg, vpres_next;
    logic [31:0]          vused_reg [NUM_VIEWS];
    logic [31:0]          vused_next [NUM_VIEWS];
    logic [SLOTS-1:0]     gvalid_reg, gvalid_next;
    logic [31:0]          mem_app [SLOTS];
    logic [31:0]          mem_amt [SLOTS];
    logic [31:0]          rd_app_reg, rd_amt_reg;

    // Scan engine
    logic             scan_on_reg, rd_vld_reg, rank_mode_reg;
    logic [CNT_W-1:0] scan_cnt_reg, rd_j_reg, outer_reg, rank_reg;
    logic             match_found_reg, free_found_reg;
    logic [CNT_W-1:0] match_idx_reg, free_idx_reg;
    logic [31:0]      match_amt_reg;
    logic             cand_vld_reg, found_reg;
    logic [31:0]      cand_app_reg, cand_amt_reg, fnd_app_reg, fnd_amt_reg;

    // Result register
    logic        out_vld_reg;
    logic [2:0]  out_status_reg;
    logic [31:0] out_value_reg, out_entry_reg;

    logic [2:0]        v_res;
    logic [VIEW_W-1:0] vi;
    logic [SLOT_W-1:0] vbase, rd_addr, j_addr, outer_addr;
    logic              pres_now, j_valid;
    logic [31:0]       used_now;

    // Finish datapath
    logic        mem_we;
    logic [SLOT_W-1:0] wr_addr;
    logic [2:0]  res_status;
    logic [31:0] res_value, res_entry;
    logic [32:0] top, diff;
    logic [CNT_W-1:0] pick;

    assign v_res      = (in_data[2:0] == 3'd0) ? sysv_reg : in_data[2:0];
    assign vi         = VIEW_W'(slot_reg);
    assign vbase      = SLOT_W'(SLOT_W'(vi) * APPS_S);
    assign pres_now   = in_range_reg && vpres_reg[vi];
    assign used_now   = vused_reg[vi];
    assign j_addr     = SLOT_W'(vbase + SLOT_W'(rd_j_reg));
    assign outer_addr = SLOT_W'(vbase + SLOT_W'(outer_reg));
    assign rd_addr    = scan_on_reg ? SLOT_W'(vbase + SLOT_W'(scan_cnt_reg)) : outer_addr;
    assign j_valid    = gvalid_reg[j_addr];

    // Status to the sequencer
    always_comb begin
        st.need_scan  = (kind_reg == K_ACQUIRE) ? in_range_reg :
                        (kind_reg == K_RELEASE || kind_reg == K_AVAIL ||
                         kind_reg == K_USAGE) ? pres_now : 1'b0;
        st.need_rank  = (kind_reg == K_ENTRY) && pres_now;
        st.scan_done  = !scan_on_reg && !rd_vld_reg;
        st.cand_valid = gvalid_reg[outer_addr];
        st.rank_hit   = cand_vld_reg && (RK_W'(rank_reg) == RK_W'(idx_reg));
        st.outer_last = (outer_reg == LAST_J);
        st.out_busy   = out_vld_reg && !out_ready;
    end

    // Result and state updates for the finishing step
    always_comb begin
        vpres_next  = vpres_reg;
        vused_next  = vused_reg;
        gvalid_next = gvalid_reg;
        mem_we      = 1'b0;
        pick        = match_found_reg ? match_idx_reg : free_idx_reg;
        wr_addr     = SLOT_W'(vbase + SLOT_W'(pick));
        res_status  = ST_OK;
        res_value   = '0;
        res_entry   = '0;
        top         = {1'b0, cap_reg} +
                      ((cnta_reg && match_found_reg) ? {1'b0, match_amt_reg} : 33'd0);
        diff        = top - {1'b0, used_now};

        // Acquire on an absent view creates it empty
        if (cmd.prep && kind_reg == K_ACQUIRE && in_range_reg && !vpres_reg[vi]) begin
            vpres_next[vi] = 1'b1;
            vused_next[vi] = '0;
            for (int i = 0; i < APPS_PER_VIEW; i++)
                gvalid_next[SLOT_W'(vbase + SLOT_W'(i))] = 1'b0;
        end

        case (kind_reg)
            K_ACQUIRE: begin
                if (!in_range_reg) res_status = ST_NO_VIEW;
                else if ({1'b0, used_now} + {1'b0, amt_reg} > {1'b0, cap_reg})
                    res_status = ST_OVER;
                else if (!match_found_reg && !free_found_reg) res_status = ST_FULL;
                else begin
                    res_value = amt_reg;
                    if (cmd.finish) begin
                        mem_we               = 1'b1;
                        gvalid_next[wr_addr] = 1'b1;
                        vused_next[vi]       = used_now + amt_reg;
                    end
                end
            end
            K_RELEASE: begin
                if (!pres_now) res_status = ST_NO_VIEW;
                else if (!match_found_reg) res_status = ST_NO_ENTRY;
                else begin
                    res_value = match_amt_reg;
                    if (cmd.finish) begin
                        gvalid_next[SLOT_W'(vbase + SLOT_W'(match_idx_reg))] = 1'b0;
                        vused_next[vi] = used_now - match_amt_reg;
                    end
                end
            end
            K_AVAIL: begin
                if (!pres_now) res_value = cap_reg;
                else if (top <= {1'b0, used_now}) res_value = '0;
                else if (diff[32]) res_value = '1;
                else res_value = diff[31:0];
            end
            K_USAGE: begin
                if (!pres_now) res_status = ST_NO_VIEW;
                else if (!match_found_reg) res_status = ST_NO_ENTRY;
                else res_value = match_amt_reg;
            end
            K_USED: begin
                if (!pres_now) res_status = ST_NO_VIEW;
                else res_value = used_now;
            end
            K_ENTRY: begin
                if (!pres_now) res_status = ST_NO_VIEW;
                else if (!found_reg) res_status = ST_NO_ENTRY;
                else begin
                    res_value = fnd_amt_reg;
                    res_entry = fnd_app_reg;
                end
            end
            K_DELETE: begin
                if (slot_reg == sysv_reg) res_status = ST_PROTECTED;
                else if (!pres_now) res_status = ST_NO_VIEW;
                else if (cmd.finish) begin
                    vpres_next[vi] = 1'b0;
                    vused_next[vi] = '0;
                    for (int i = 0; i < APPS_PER_VIEW; i++)
                        gvalid_next[SLOT_W'(vbase + SLOT_W'(i))] = 1'b0;
                end
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg     <= 32'd1;
            sysv_reg    <= '0;
            vpres_reg   <= '0;
            gvalid_reg  <= '0;
            scan_on_reg <= 1'b0;
            rd_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            for (int v = 0; v < NUM_VIEWS; v++) vused_reg[v] <= '0;
        end else begin
            if (cfg_we && cfg_index == REG_CAPACITY) cap_reg <= cfg_value;
            if (cfg_we && cfg_index == REG_SYSVIEW)  sysv_reg <= cfg_value[2:0];
            vpres_reg  <= vpres_next;
            vused_reg  <= vused_next;
            gvalid_reg <= gvalid_next;
            // one read issued per cycle while the scan runs
            rd_vld_reg <= scan_on_reg;
            if (cmd.scan_go) scan_on_reg <= 1'b1;
            else if (scan_on_reg && scan_cnt_reg == LAST_J) scan_on_reg <= 1'b0;
            if (cmd.finish) out_vld_reg <= 1'b1;
            else if (out_ready) out_vld_reg <= 1'b0;
        end
    end

    // Payload and scan bookkeeping
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg     <= in_kind;
            slot_reg     <= v_res;
            in_range_reg <= ({5'd0, v_res} < 8'(NUM_VIEWS)) || (NUM_VIEWS > 8);
            app_reg      <= in_data[34:3];
            amt_reg      <= in_data[66:35];
            idx_reg      <= in_data[70:67];
            cnta_reg     <= in_data[71];
            outer_reg    <= '0;
            found_reg    <= 1'b0;
        end
        if (cmd.outer_inc) outer_reg <= outer_reg + 1'b1;
        if (cmd.scan_go) begin
            scan_cnt_reg    <= '0;
            rank_mode_reg   <= cmd.rank_mode;
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
            rank_reg        <= '0;
        end else if (scan_on_reg) begin
            scan_cnt_reg <= scan_cnt_reg + 1'b1;
        end
        rd_j_reg <= scan_cnt_reg;
        if (rd_vld_reg) begin
            if (rank_mode_reg) begin
                if (j_valid && rd_app_reg < cand_app_reg) rank_reg <= rank_reg + 1'b1;
            end else begin
                if (j_valid && rd_app_reg == app_reg && !match_found_reg) begin
                    match_found_reg <= 1'b1;
                    match_idx_reg   <= rd_j_reg;
                    match_amt_reg   <= rd_amt_reg;
                end
                if (!j_valid && !free_found_reg) begin
                    free_found_reg <= 1'b1;
                    free_idx_reg   <= rd_j_reg;
                end
            end
        end
        if (cmd.cand_load) begin
            cand_vld_reg <= st.cand_valid;
            cand_app_reg <= rd_app_reg;
            cand_amt_reg <= rd_amt_reg;
        end
        if (cmd.found) begin
            found_reg   <= 1'b1;
            fnd_app_reg <= cand_app_reg;
            fnd_amt_reg <= cand_amt_reg;
        end
        if (cmd.finish) begin
            out_status_reg <= res_status;
            out_value_reg  <= res_value;
            out_entry_reg  <= res_entry;
        end
    end

    // Grant memory
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem_app[wr_addr] <= app_reg;
            mem_amt[wr_addr] <= amt_reg;
        end
        rd_app_reg <= mem_app[rd_addr];
        rd_amt_reg <= mem_amt[rd_addr];
    end

    assign out_valid = out_vld_reg;
    assign out_data  = {5'd0, out_entry_reg, out_value_reg, out_status_reg};

`ifndef SYNTHESIS
    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        scan_on_reg |-> (scan_cnt_reg <= LAST_J))
        else $error("scan counter past table end");
    a_rd_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_vld_reg |-> $past(scan_on_reg))
        else $error("read return without issued scan read");
    a_no_finish_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> (!out_vld_reg || out_ready))
        else $error("result overwritten while held");
    a_lookup_rank: assert property (@(posedge aclk) disable iff (!aresetn)
        (rd_vld_reg && !rank_mode_reg) |=> $stable(rank_reg) || $past(cmd.scan_go))
        else $error("rank counted during lookup scan");
`endif

endmodule
`default_nettype wire

/* rtl/core/resource_usage_accounting_core.sv */
// Lookup kinds run one 16-entry scan of the view's grant memory, one read a cycle;
//   used and delete run no scan; entry by index runs a rank scan of 16 entries per
//   candidate through the single read port.
// Throughput: one item at a time; the next item is taken while the result register waits.
// Reset: aresetn synchronous, active low; clears all views, grant valid bits, capacity 1.
`default_nettype none
module resource_usage_accounting_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // view[2:0], app_id[34:3], amount[66:35], entry_index[70:67], count_app[71]
    input  wire logic [71:0] s_tdata,
    // kind[2:0]
    input  wire logic [2:0]  s_tuser,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // status[2:0], value[34:3], entry_app[66:35], zero fill above
    output logic [71:0]      m_tdata
);
    import rua_pkg::*;

    cmd_t  cmd;
    stat_t st;

    assign cfg_ready = 1'b1;

    rua_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    rua_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_kind   (s_tuser),
        .in_data   (s_tdata),
        .cfg_we    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_value (cfg_data),
        .cmd       (cmd),
        .st        (st),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule
`default_nettype wire
